[sv/mad_pkg.sv]
// ----------------------------------------------------------------------------
// mad_pkg - shared constants and types for the modulated audio delay line
// Register indexes, field widths, queue depth and the configuration write
// bundle passed from the top level to the front end.
// ----------------------------------------------------------------------------
package mad_pkg;

	localparam int DEF_MAX_LENGTH   = 65536;
	localparam int DEF_SAMPLE_WIDTH = 24;

	// configuration port
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd1;

	// reset value of line_length
	localparam int LEN_RESET = 65536;

	// modulation field: signed Q1.15
	localparam int MOD_W    = 16;
	localparam int MOD_FRAC = 15;

	// queue between front and back, power of two
	localparam int QDEPTH = 8;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

endpackage

[sv/mad_ram.sv]
// ----------------------------------------------------------------------------
// mad_ram - generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module mad_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/mad_front.sv]
// ----------------------------------------------------------------------------
// mad_front - accept items, compute the tap and access the delay store
// Holds the configuration, write pointer and fill count; runs a three-stage
// tap pipeline and pushes (dry, wet) pairs into the queue. Credits bound
// the number of items between acceptance and the queue pop.
// ----------------------------------------------------------------------------
module mad_front
	import mad_pkg::*;
#(
	parameter int MAX_LENGTH   = DEF_MAX_LENGTH,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_wr_t                   cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SAMPLE_WIDTH-1:0]   in_sample,
	input  logic [MOD_W-1:0]          in_mod,
	input  logic                      pop,
	output logic                      push_valid,
	output logic [2*SAMPLE_WIDTH-1:0] push_data
);

	localparam int ADDR_W = $clog2(MAX_LENGTH);
	localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
	localparam int PROD_W = LEN_W + MOD_W + 1;
	localparam int Q_W    = LEN_W + 2;
	localparam int PEND_W = $clog2(QDEPTH + 1);
	localparam int LEN_RST = (MAX_LENGTH < LEN_RESET) ? MAX_LENGTH : LEN_RESET;

	// configuration
	logic [LEN_W-1:0]       len_q;
	logic [CFG_W-1:0]       delay_q;
	logic [LEN_W-1:0]       base_q;
	logic signed [Q_W-1:0]  base_m_len_q;
	logic [LEN_W-1:0]       base_nx;
	logic [31:0]            cfg_val;

	// pointers and credits
	logic [ADDR_W-1:0]      wp_q;
	logic [LEN_W-1:0]       fill_q;
	logic [LEN_W-1:0]       fill_nx;
	logic [PEND_W-1:0]      pend_q;
	logic                   accept;
	logic                   clr;

	// stage 1
	logic                     v_s1;
	logic [SAMPLE_WIDTH-1:0]  sample_s1;
	logic [ADDR_W-1:0]        wp_s1;
	logic [LEN_W-1:0]         fill_s1;
	logic signed [PROD_W-1:0] prod_s1;

	// stage 2
	logic                     v_s2;
	logic [SAMPLE_WIDTH-1:0]  sample_s2;
	logic [ADDR_W-1:0]        wp_s2;
	logic [LEN_W-1:0]         fill_s2;
	logic [ADDR_W-1:0]        dist_s2;
	logic signed [Q_W-1:0]    sh;
	logic signed [Q_W-1:0]    tap_a;
	logic signed [Q_W-1:0]    tap_b;
	logic [ADDR_W-1:0]        dist_nx;

	// stage 3
	logic                     v_s3;
	logic [SAMPLE_WIDTH-1:0]  sample_s3;
	logic                     bypass_s3;
	logic                     hit_s3;
	logic [LEN_W:0]           rp_diff;
	logic [ADDR_W-1:0]        rp;
	logic [SAMPLE_WIDTH-1:0]  rdata;
	logic [SAMPLE_WIDTH-1:0]  wet;

	assign cfg_val  = 32'(cfg.data);
	assign clr      = cfg.we && (cfg.index == REG_LINE_LENGTH);
	assign in_ready = (pend_q < PEND_W'(QDEPTH));
	assign accept   = in_valid && in_ready;
	assign base_nx  = (32'(delay_q) > 32'(len_q)) ? len_q : LEN_W'(delay_q);
	assign fill_nx  = (fill_q < len_q) ? fill_q + LEN_W'(1) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= LEN_W'(LEN_RST);
			delay_q      <= '0;
			base_q       <= '0;
			base_m_len_q <= -$signed(Q_W'(LEN_RST));
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					REG_LINE_LENGTH: begin
						if (cfg_val == 32'd0) begin
							len_q <= LEN_W'(1);
						end else if (cfg_val > 32'(MAX_LENGTH)) begin
							len_q <= LEN_W'(MAX_LENGTH);
						end else begin
							len_q <= LEN_W'(cfg_val);
						end
					end
					REG_DELAY_SAMPLES: begin
						delay_q <= cfg.data;
					end
					default: begin
					end
				endcase
			end
			// clamp base delay to the length; keep base - length ready for the wrap
			base_q       <= base_nx;
			base_m_len_q <= $signed({2'b00, base_nx}) - $signed({2'b00, len_q});
		end
	end

	// write pointer, fill count and credits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			pend_q <= '0;
		end else begin
			if (clr) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else if (accept) begin
				wp_q   <= ((LEN_W'(wp_q) + LEN_W'(1)) < len_q) ? wp_q + ADDR_W'(1) : '0;
				fill_q <= fill_nx;
			end
			case ({accept, pop})
				2'b10:   pend_q <= pend_q + PEND_W'(1);
				2'b01:   pend_q <= pend_q - PEND_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: modulation times length
	always_ff @(posedge clk) begin
		sample_s1 <= in_sample;
		wp_s1     <= wp_q;
		fill_s1   <= fill_nx;
		prod_s1   <= $signed(PROD_W'($signed({1'b0, len_q}))) *
			$signed(PROD_W'($signed(in_mod)));
	end

	// stage 2: tap distance = clamp(base + floor(prod / 2^15)) mod length
	assign sh    = $signed(prod_s1[PROD_W-1:MOD_FRAC]);
	assign tap_a = $signed({2'b00, base_q}) + sh;
	assign tap_b = base_m_len_q + sh;

	always_comb begin
		if (tap_a[Q_W-1]) begin
			dist_nx = '0;
		end else if (!tap_b[Q_W-1]) begin
			dist_nx = tap_b[ADDR_W-1:0];
		end else begin
			dist_nx = tap_a[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		sample_s2 <= sample_s1;
		wp_s2     <= wp_s1;
		fill_s2   <= fill_s1;
		dist_s2   <= dist_nx;
	end

	// stage 3: read pointer, store access
	assign rp_diff = (LEN_W+1)'(wp_s2) - (LEN_W+1)'(dist_s2);
	assign rp = (wp_s2 < dist_s2) ? ADDR_W'(rp_diff + {1'b0, len_q}) : ADDR_W'(rp_diff);

	mad_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (MAX_LENGTH)
	) u_ram (
		.clk   (clk),
		.we    (v_s2),
		.waddr (wp_s2),
		.wdata (sample_s2),
		.raddr (rp),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		sample_s3 <= sample_s2;
		bypass_s3 <= (dist_s2 == '0);
		hit_s3    <= (LEN_W'(rp) < fill_s2);
	end

	// zero distance returns the dry sample; unwritten entries read as zero
	always_comb begin
		if (bypass_s3) begin
			wet = sample_s3;
		end else if (hit_s3) begin
			wet = rdata;
		end else begin
			wet = '0;
		end
	end

	assign push_valid = v_s3;
	assign push_data  = {sample_s3, wet};

endmodule

[sv/mad_queue.sv]
// ----------------------------------------------------------------------------
// mad_queue - short register FIFO between front and back
// Overflow is prevented upstream by the front end's credit count.
// ----------------------------------------------------------------------------
module mad_queue #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/mad_back.sv]
// ----------------------------------------------------------------------------
// mad_back - saturating mix and output register
// Pops (dry, wet) pairs, adds them with saturation and holds the result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module mad_back #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  logic [2*SAMPLE_WIDTH-1:0] head_data,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [SAMPLE_WIDTH-1:0]   out_delayed,
	output logic [SAMPLE_WIDTH-1:0]   out_mix
);

	localparam int SW = SAMPLE_WIDTH;

	logic          valid_q;
	logic [SW-1:0] wet_q;
	logic [SW-1:0] mix_q;
	logic [SW-1:0] wet;
	logic [SW-1:0] dry;
	logic [SW:0]   sum;
	logic [SW-1:0] mix;

	assign wet = head_data[SW-1:0];
	assign dry = head_data[2*SW-1:SW];
	assign sum = {wet[SW-1], wet} + {dry[SW-1], dry};

	// clip to full scale when the two top bits disagree
	always_comb begin
		if (sum[SW] != sum[SW-1]) begin
			mix = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			mix = sum[SW-1:0];
		end
	end

	assign pop = head_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wet_q <= wet;
			mix_q <= mix;
		end
	end

	assign out_valid   = valid_q;
	assign out_delayed = wet_q;
	assign out_mix     = mix_q;

endmodule

[sv/modulated_audio_delay_line_top.sv]
// ----------------------------------------------------------------------------
// modulated_audio_delay_line_top - circular delay line with modulated tap
// An accepted input passes the tap stages, the queue and the output register.
// Throughput: one item per cycle while credits last; up to QDEPTH items may
// sit between accept and the output register (credit count in the front end).
// Reset: clears pointers, fill count, queue and output valid; the store is
// not swept, unwritten entries read as zero through the fill count.
// ----------------------------------------------------------------------------
module modulated_audio_delay_line_top
	import mad_pkg::*;
#(
	parameter int MAX_LENGTH   = DEF_MAX_LENGTH,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// tdata, low bit up: sample, modulation, zero pad to bytes
	input  logic [((SAMPLE_WIDTH+MOD_W+7)/8)*8-1:0] s_axis_tdata,
	// output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// tdata, low bit up: delayed, delayed_plus_dry, zero pad to bytes
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int OUT_W = ((2*SAMPLE_WIDTH+7)/8)*8;

	cfg_wr_t         cfg;
	logic            push_valid;
	logic [2*SW-1:0] push_data;
	logic            head_valid;
	logic [2*SW-1:0] head_data;
	logic            pop;
	logic [SW-1:0]   delayed;
	logic [SW-1:0]   mixed;

	// bundle the configuration write for the front end
	assign cfg.we    = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_wr_data;

	// front: accept, compute the tap, write and read the delay store
	mad_front #(
		.MAX_LENGTH   (MAX_LENGTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_sample  (s_axis_tdata[SW-1:0]),
		.in_mod     (s_axis_tdata[SW+MOD_W-1:SW]),
		.pop        (pop),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// queue: decouple the store pipeline from output stalls
	mad_queue #(
		.WIDTH (2*SW),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// back: mix with saturation, hold the result for the consumer
	mad_back #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_delayed (delayed),
		.out_mix     (mixed)
	);

	// pack result, zero pad to whole bytes
	assign m_axis_tdata = OUT_W'({mixed, delayed});

endmodule

[sv/mad_checker.sv]
// ----------------------------------------------------------------------------
// mad_checker - port-level assertions for the delay line top
// Tracks items accepted but not yet delivered and checks credit and output
// behavior against it.
// ----------------------------------------------------------------------------
module mad_checker
	import mad_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	localparam int OUT_CNT_W = $clog2(QDEPTH + 2) + 1;

	logic                 acc_in;
	logic                 acc_out;
	logic [OUT_CNT_W-1:0] open_q;

	assign acc_in  = s_axis_tvalid && s_axis_tready;
	assign acc_out = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			case ({acc_in, acc_out})
				2'b10:   open_q <= open_q + OUT_CNT_W'(1);
				2'b01:   open_q <= open_q - OUT_CNT_W'(1);
				default: open_q <= open_q;
			endcase
		end
	end

	// no result without an accepted item behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (open_q != '0))
		else $error("result shown with no item outstanding");

	// credit window bounds the items in flight
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OUT_CNT_W'(QDEPTH + 1))
		else $error("too many items in flight");

	// input is held off only when the credit window is full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (open_q >= OUT_CNT_W'(QDEPTH)))
		else $error("input stalled with credits left");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind modulated_audio_delay_line_top mad_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
